### rtl/vertex_clip_and_viewport_macros.svh
// ---------------------------------------------------------------------------
// Vertex clip and viewport assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ---------------------------------------------------------------------------
`ifndef VERTEX_CLIP_AND_VIEWPORT_MACROS_SVH
`define VERTEX_CLIP_AND_VIEWPORT_MACROS_SVH

// same-cycle implication
`define VCV_ASSERT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define VCV_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/vcv_pkg.sv
// ---------------------------------------------------------------------------
// vcv_pkg
// Constants shared by the vertex clip and viewport block.
// ---------------------------------------------------------------------------
package vcv_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int CFG_WIDTH     = 13;
    localparam int CFG_IDX_WIDTH = 8;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_VIEWPORT_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_VIEWPORT_HEIGHT = 8'd1;

    localparam logic [CFG_WIDTH-1:0] VIEWPORT_WIDTH_RST  = 13'd640;
    localparam logic [CFG_WIDTH-1:0] VIEWPORT_HEIGHT_RST = 13'd480;

endpackage

### rtl/vertex_clip_and_viewport.sv
// ---------------------------------------------------------------------------
// vertex_clip_and_viewport
// Clip test, perspective divide and viewport transform of one vertex a beat.
// ---------------------------------------------------------------------------
// Takes one clip-space vertex per cycle while the pipeline is not held and
// returns one result beat per vertex, in order. The quotients come from the
// four radix-2 restoring dividers (x/w, y/w, z/w, 1/w), which resolve one
// quotient bit per pipeline stage. A two-entry output (register plus skid)
// keeps the input open while one result waits; the pipeline only holds when
// both are full. Viewport registers are sampled live and must only be
// written while the block is empty.
module vertex_clip_and_viewport #(
    parameter int FRAC_BITS   = vcv_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = vcv_pkg::COORD_WIDTH_DEF,
    localparam int ITW = ((4 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OTW = ((4 * COORD_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vcv_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [vcv_pkg::CFG_WIDTH-1:0]     cfg_data,
    // vertex in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ITW-1:0]                    s_tdata,  // clip_x, clip_y, clip_z, clip_w
    // result out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OTW-1:0]                    m_tdata,  // inside_res, raster_x, raster_y,
                                                        // depth, inv_w
    output logic                              m_tuser   // w_zero
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = CW + 2 * FRAC_BITS;
    localparam int PW = CW + 1 + vcv_pkg::CFG_WIDTH + 1;
    localparam int SW = PW + 1;
    localparam logic [CW-1:0] CAPM = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [CW-1:0] qn;
        logic          ovf;
        logic          neg;
    } lane_t;

    typedef struct packed {
        lane_t [3:0]   lane;
        logic [CW-1:0] d;
        logic          in_clip;
        logic          wz;
    } div_t;

    typedef struct packed {
        logic          in_clip;
        logic [CW-1:0] rx;
        logic [CW-1:0] ry;
        logic [CW-1:0] dz;
        logic [CW-1:0] iw;
        logic          wz;
    } res_t;

    logic [vcv_pkg::CFG_WIDTH-1:0] vp_w_reg, vp_h_reg;
    logic pipe_en;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_w_reg <= vcv_pkg::VIEWPORT_WIDTH_RST;
            vp_h_reg <= vcv_pkg::VIEWPORT_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vcv_pkg::REG_VIEWPORT_WIDTH:  vp_w_reg <= cfg_data;
                vcv_pkg::REG_VIEWPORT_HEIGHT: vp_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage: input register ----------------
    logic signed [CW-1:0] in_x_reg, in_y_reg, in_z_reg, in_w_reg;
    logic in_v_reg;

    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            in_x_reg <= s_tdata[CW-1:0];
            in_y_reg <= s_tdata[2*CW-1:CW];
            in_z_reg <= s_tdata[3*CW-1:2*CW];
            in_w_reg <= s_tdata[4*CW-1:3*CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)     in_v_reg <= 1'b0;
        else if (pipe_en) in_v_reg <= s_tvalid;
    end

    // ---------------- stage: magnitudes and clip test ----------------
    logic [CW-1:0] ab_x_reg, ab_y_reg, ab_z_reg, ab_w_reg;
    logic [CW-1:0] ab_x_next, ab_y_next, ab_z_next, ab_w_next;
    logic [3:0]    ab_neg_reg, ab_neg_next;
    logic          ab_inside_reg, ab_inside_next, ab_wz_reg, ab_wz_next, ab_v_reg;
    logic signed [CW:0] xe, ye, ze, we, nwe;

    always_comb begin
        ab_x_next = in_x_reg[CW-1] ? (~in_x_reg + 1'b1) : in_x_reg;
        ab_y_next = in_y_reg[CW-1] ? (~in_y_reg + 1'b1) : in_y_reg;
        ab_z_next = in_z_reg[CW-1] ? (~in_z_reg + 1'b1) : in_z_reg;
        ab_w_next = in_w_reg[CW-1] ? (~in_w_reg + 1'b1) : in_w_reg;
        ab_neg_next[0] = in_x_reg[CW-1] ^ in_w_reg[CW-1];
        ab_neg_next[1] = in_y_reg[CW-1] ^ in_w_reg[CW-1];
        ab_neg_next[2] = in_z_reg[CW-1] ^ in_w_reg[CW-1];
        ab_neg_next[3] = in_w_reg[CW-1];
        xe  = {in_x_reg[CW-1], in_x_reg};
        ye  = {in_y_reg[CW-1], in_y_reg};
        ze  = {in_z_reg[CW-1], in_z_reg};
        we  = {in_w_reg[CW-1], in_w_reg};
        nwe = -we;
        ab_inside_next = (xe >= nwe) && (xe <= we) && (ye >= nwe) && (ye <= we)
                      && (ze >= nwe) && (ze <= we);
        ab_wz_next = (in_w_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ab_x_reg      <= ab_x_next;
            ab_y_reg      <= ab_y_next;
            ab_z_reg      <= ab_z_next;
            ab_w_reg      <= ab_w_next;
            ab_neg_reg    <= ab_neg_next;
            ab_inside_reg <= ab_inside_next;
            ab_wz_reg     <= ab_wz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)     ab_v_reg <= 1'b0;
        else if (pipe_en) ab_v_reg <= in_v_reg;
    end

    // ---------------- divider pipeline ----------------
    // dv_reg[0] holds the set-up values, dv_reg[k] the state after k steps.
    div_t        dv_reg [CW+1];
    div_t        dv_next[CW+1];
    logic [CW:0] dvv_reg;

    always_comb begin
        logic [NW-1:0] num [4];
        logic [NW-1:0] hi;
        num[0] = {{(NW-CW){1'b0}}, ab_x_reg} << FRAC_BITS;
        num[1] = {{(NW-CW){1'b0}}, ab_y_reg} << FRAC_BITS;
        num[2] = {{(NW-CW){1'b0}}, ab_z_reg} << FRAC_BITS;
        num[3] = NW'(1) << (2 * FRAC_BITS);
        dv_next[0].d       = ab_w_reg;
        dv_next[0].in_clip = ab_inside_reg;
        dv_next[0].wz      = ab_wz_reg;
        for (int l = 0; l < 4; l++) begin
            // quotient bits above CW mean the result is out of range
            hi = num[l] >> CW;
            dv_next[0].lane[l].ovf = hi >= {{(NW-CW){1'b0}}, ab_w_reg};
            dv_next[0].lane[l].rem = hi[CW-1:0];
            dv_next[0].lane[l].qn  = num[l][CW-1:0];
            dv_next[0].lane[l].neg = ab_neg_reg[l];
        end
    end

    for (genvar k = 1; k <= CW; k++) begin : g_step
        always_comb begin
            logic [CW:0] r2;
            logic        qb;
            dv_next[k] = dv_reg[k-1];
            for (int l = 0; l < 4; l++) begin
                r2 = {dv_reg[k-1].lane[l].rem, dv_reg[k-1].lane[l].qn[CW-1]};
                qb = r2 >= {1'b0, dv_reg[k-1].d};
                if (qb) r2 = r2 - {1'b0, dv_reg[k-1].d};
                dv_next[k].lane[l].rem = r2[CW-1:0];
                dv_next[k].lane[l].qn  = {dv_reg[k-1].lane[l].qn[CW-2:0], qb};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k <= CW; k++) dv_reg[k] <= dv_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)     dvv_reg <= '0;
        else if (pipe_en) dvv_reg <= {dvv_reg[CW-1:0], ab_v_reg};
    end

    // ---------------- stage: sign and saturation of quotients ----------------
    logic signed [CW-1:0] nd_reg [4];
    logic signed [CW-1:0] nd_next[4];
    logic nd_inside_reg, nd_wz_reg, nd_v_reg;

    always_comb begin
        logic [CW-1:0] capv, qs;
        for (int l = 0; l < 4; l++) begin
            capv = dv_reg[CW].lane[l].neg ? CAPM : CAPM - 1'b1;
            qs = (dv_reg[CW].lane[l].ovf || dv_reg[CW].lane[l].qn > capv)
               ? capv : dv_reg[CW].lane[l].qn;
            nd_next[l] = dv_reg[CW].lane[l].neg ? (~qs + 1'b1) : qs;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int l = 0; l < 4; l++) nd_reg[l] <= nd_next[l];
            nd_inside_reg <= dv_reg[CW].in_clip;
            nd_wz_reg     <= dv_reg[CW].wz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)     nd_v_reg <= 1'b0;
        else if (pipe_en) nd_v_reg <= dvv_reg[CW];
    end

    // ---------------- stage: viewport products ----------------
    logic signed [PW-1:0] mu_px_reg, mu_py_reg, mu_px_next, mu_py_next;
    logic signed [CW-1:0] mu_dz_reg, mu_iw_reg;
    logic mu_inside_reg, mu_wz_reg, mu_v_reg;

    always_comb begin
        logic signed [CW:0] sx, sy;
        logic signed [vcv_pkg::CFG_WIDTH:0] ws, hs;
        sx = {nd_reg[0][CW-1], nd_reg[0]} + (CW+1)'(1 << FRAC_BITS);
        sy = {nd_reg[1][CW-1], nd_reg[1]} + (CW+1)'(1 << FRAC_BITS);
        ws = {1'b0, vp_w_reg};
        hs = {1'b0, vp_h_reg};
        mu_px_next = PW'(sx) * PW'(ws);
        mu_py_next = PW'(sy) * PW'(hs);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mu_px_reg     <= mu_px_next;
            mu_py_reg     <= mu_py_next;
            mu_dz_reg     <= nd_reg[2];
            mu_iw_reg     <= nd_reg[3];
            mu_inside_reg <= nd_inside_reg;
            mu_wz_reg     <= nd_wz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)     mu_v_reg <= 1'b0;
        else if (pipe_en) mu_v_reg <= nd_v_reg;
    end

    // ---------------- stage: halve, flip, saturate ----------------
    res_t fn_reg, fn_next;
    logic fn_v_reg;

    function automatic logic [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi, lo;
        hi = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
        lo = -hi - SW'(1);
        if (v > hi)      sat_cw = hi[CW-1:0];
        else if (v < lo) sat_cw = lo[CW-1:0];
        else             sat_cw = v[CW-1:0];
    endfunction

    always_comb begin
        logic signed [SW-1:0] vx, vy, hoff;
        hoff = SW'({1'b0, vp_h_reg}) <<< (FRAC_BITS + 1);
        vx = SW'(mu_px_reg) >>> 1;
        vy = (hoff - SW'(mu_py_reg)) >>> 1;
        fn_next.in_clip = mu_inside_reg;
        fn_next.rx      = sat_cw(vx);
        fn_next.ry      = sat_cw(vy);
        fn_next.dz      = mu_dz_reg;
        fn_next.iw      = mu_iw_reg;
        fn_next.wz      = 1'b0;
        if (mu_wz_reg) begin
            fn_next    = '0;
            fn_next.wz = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) fn_reg <= fn_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)     fn_v_reg <= 1'b0;
        else if (pipe_en) fn_v_reg <= mu_v_reg;
    end

    // ---------------- output register and skid ----------------
    res_t m_res_reg, skid_reg;
    logic m_tvalid_reg, skid_v_reg;

    assign pipe_en = !skid_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_v_reg   <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            if (skid_v_reg) begin
                m_tvalid_reg <= 1'b1;
                skid_v_reg   <= 1'b0;
            end else begin
                m_tvalid_reg <= fn_v_reg;
            end
        end else if (fn_v_reg) begin
            // skid takes the beat if it is empty; if it is full the pipeline is held
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            m_res_reg <= skid_v_reg ? skid_reg : fn_reg;
        end else if (!skid_v_reg) begin
            skid_reg <= fn_reg;
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[0]           = m_res_reg.in_clip;
        m_tdata[CW:1]        = m_res_reg.rx;
        m_tdata[2*CW:CW+1]   = m_res_reg.ry;
        m_tdata[3*CW:2*CW+1] = m_res_reg.dz;
        m_tdata[4*CW:3*CW+1] = m_res_reg.iw;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.wz;

    // ---------------- assertions ----------------
`include "vertex_clip_and_viewport_macros.svh"

    `VCV_ASSERT(a_skid_needs_out, skid_v_reg, m_tvalid_reg, "skid holds a beat with output empty")
    `VCV_ASSERT(a_wzero_clears, m_tvalid_reg && m_res_reg.wz, m_tdata == '0, "w zero beat not cleared")
    `VCV_ASSERT_NEXT(a_pipe_holds, !pipe_en, $stable(dvv_reg), "divider valids moved during hold")

endmodule

### bench/vertex_clip_and_viewport_test.sv
// ---------------------------------------------------------------------------
// vertex_clip_and_viewport_test
// Streams clip-space vertices through the block under several viewport
// sizes and compares each result beat with an in-bench predictor of the
// clip test, perspective divide and viewport transform.
// ---------------------------------------------------------------------------
module vertex_clip_and_viewport_test;

    localparam int FB = vcv_pkg::FRAC_BITS_DEF;
    localparam int CW = vcv_pkg::COORD_WIDTH_DEF;
    localparam int CFGW = vcv_pkg::CFG_WIDTH;
    localparam int LATENCY = CW + 6;
    localparam longint MAXPOS = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint MINNEG = -MAXPOS - 1;
    localparam logic [31:0] PMAX = 32'h7fff_ffff;
    localparam logic [31:0] NMAX = 32'h8000_0000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    typedef struct packed {
        logic [31:0] w;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } vertex_t;

    typedef struct {
        logic        in_clip;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] depth;
        logic [31:0] inv_w;
        logic        w_zero;
    } raster_t;

    // directed rows; known==1 means the result column is typed in
    typedef struct {
        vertex_t v;
        bit      known;
        raster_t r;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [vcv_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [CFGW-1:0] cfg_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [135:0] m_tdata;
    logic m_tuser;

    vertex_clip_and_viewport dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

    longint vp_w = 640, vp_h = 480;
    raster_t expected_q[$];
    int errors = 0;
    int beats_out = 0;
    int vertices_in = 0;
    int holdoff = 0;
    int hold_len = 0;
    int hold_req = 0;
    int hold_ack = 0;
    bit rx_steady = 0;

    // (n << s) / d truncated toward zero, saturated, d nonzero
    function automatic longint quot_sat(longint n, longint d, int s);
        bit neg;
        longint un, ud, q, r, cap;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        cap = neg ? MAXPOS + 1 : MAXPOS;
        q = un / ud;
        r = un % ud;
        if (q >= cap) return neg ? -cap : cap;
        for (int i = 0; i < s; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= ud) begin
                r -= ud;
                q |= 1;
            end
            if (q >= cap) return neg ? -cap : cap;
        end
        return neg ? -q : q;
    endfunction

    function automatic longint clamp(longint v);
        if (v > MAXPOS) return MAXPOS;
        if (v < MINNEG) return MINNEG;
        return v;
    endfunction

    function automatic raster_t project_vertex(vertex_t v);
        raster_t r;
        longint x, y, z, w, nx, ny;
        x = longint'(signed'(v.x));
        y = longint'(signed'(v.y));
        z = longint'(signed'(v.z));
        w = longint'(signed'(v.w));
        r = '{default: '0};
        if (w == 0) begin
            r.w_zero = 1;
            return r;
        end
        r.in_clip = -w <= x && x <= w && -w <= y && y <= w && -w <= z && z <= w;
        nx = quot_sat(x, w, FB);
        ny = quot_sat(y, w, FB);
        r.depth = 32'(quot_sat(z, w, FB));
        r.inv_w = 32'(quot_sat(1, w, 2 * FB));
        // >>> 1 on a signed value is a floor halving
        r.rx = 32'(clamp(((nx + (64'sd1 <<< FB)) * vp_w) >>> 1));
        r.ry = 32'(clamp((2 * vp_h * (64'sd1 <<< FB) - (ny + (64'sd1 <<< FB)) * vp_h) >>> 1));
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            2: return $urandom_range(0, 1) ? PMAX - $urandom_range(0, 3) : NMAX + $urandom_range(0, 3);
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    // mostly vertices near the clip volume so inside and outside both show up
    function automatic vertex_t rand_vertex();
        vertex_t v;
        int unsigned span;
        if ($urandom_range(0, 3) == 0) begin
            v = '{x: rand_coord(), y: rand_coord(), z: rand_coord(), w: rand_coord()};
            if ($urandom_range(0, 15) == 0) v.w = '0;
            return v;
        end
        span = $urandom_range(1, 32'h0100_0000);
        v.w = $urandom_range(0, 1) ? 32'(span) : 32'(-span);
        v.x = 32'($signed($urandom_range(0, 2 * span)) - $signed(span + $urandom_range(0, 2)));
        v.y = 32'($signed($urandom_range(0, 2 * span)) - $signed(span + $urandom_range(0, 2)));
        v.z = 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
        return v;
    endfunction

    // tvalid stays up after a beat so back-to-back sends drive it once a step
    task automatic send_vertex(vertex_t v);
        while ($urandom_range(0, 99) < 14 && !rx_steady) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
        expected_q = {expected_q, project_vertex(v)};
        vertices_in++;
    endtask

    task automatic write_reg(logic [vcv_pkg::CFG_IDX_WIDTH-1:0] idx, logic [CFGW-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == vcv_pkg::REG_VIEWPORT_WIDTH) vp_w = val;
        else vp_h = val;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // receiver: random stalls, two long hold-offs to back up the pipe
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            holdoff <= hold_len;
            m_tready <= 0;
        end else if (holdoff > 0) begin
            holdoff <= holdoff - 1;
            m_tready <= 0;
        end else begin
            m_tready <= rx_steady || $urandom_range(0, 99) >= 14;
        end
    end

    always @(posedge aclk) begin
        raster_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[0] !== e.in_clip) begin
                    $error("inside_res exp %0b got %0b", e.in_clip, m_tdata[0]); errors++;
                end
                if (m_tdata[32:1] !== e.rx) begin
                    $error("raster_x exp %h got %h", e.rx, m_tdata[32:1]); errors++;
                end
                if (m_tdata[64:33] !== e.ry) begin
                    $error("raster_y exp %h got %h", e.ry, m_tdata[64:33]); errors++;
                end
                if (m_tdata[96:65] !== e.depth) begin
                    $error("depth exp %h got %h", e.depth, m_tdata[96:65]); errors++;
                end
                if (m_tdata[128:97] !== e.inv_w) begin
                    $error("inv_w exp %h got %h", e.inv_w, m_tdata[128:97]); errors++;
                end
                if (m_tuser !== e.w_zero) begin
                    $error("w_zero exp %0b got %0b", e.w_zero, m_tuser); errors++;
                end
            end
        end
    end

    row_t rows[$];
    raster_t zero_r = '{in_clip: 0, rx: 0, ry: 0, depth: 0, inv_w: 0, w_zero: 1};
    // origin at w = 1 under the reset viewport: center of 640x480, depth 0, 1/w = 1
    raster_t center_r = '{in_clip: 1, rx: 32'd320 << 16, ry: 32'd240 << 16,
                          depth: 0, inv_w: ONE, w_zero: 0};

    initial begin
        vertex_t v;
        rows = '{
            '{'{x: 0, y: 0, z: 0, w: ONE}, 1, center_r},
            '{'{x: PMAX, y: NMAX, z: PMAX, w: 0}, 1, zero_r},
            '{'{x: 0, y: 0, z: 0, w: 0}, 1, zero_r},
            '{'{x: ONE, y: ONE, z: ONE, w: ONE}, 0, zero_r},
            '{'{x: -ONE, y: -ONE, z: -ONE, w: ONE}, 0, zero_r},
            '{'{x: ONE + 1, y: 0, z: 0, w: ONE}, 0, zero_r},
            '{'{x: 0, y: -ONE - 1, z: 0, w: ONE}, 0, zero_r},
            '{'{x: PMAX, y: PMAX, z: PMAX, w: 1}, 0, zero_r},
            '{'{x: NMAX, y: NMAX, z: NMAX, w: 1}, 0, zero_r},
            '{'{x: NMAX, y: PMAX, z: NMAX, w: 32'hffff_ffff}, 0, zero_r},
            '{'{x: PMAX, y: NMAX, z: 1, w: NMAX}, 0, zero_r},
            '{'{x: NMAX, y: NMAX, z: NMAX, w: NMAX}, 0, zero_r},
            '{'{x: PMAX, y: PMAX, z: PMAX, w: PMAX}, 0, zero_r},
            '{'{x: 5, y: -5, z: 3, w: -ONE}, 0, zero_r},
            '{'{x: 32'hffff_ffff, y: 1, z: 0, w: 32'h0000_0003}, 0, zero_r},
            '{'{x: 32'h5555_5555, y: 32'haaaa_aaaa, z: 32'h0f0f_0f0f, w: 32'h1234_5678}, 0, zero_r}
        };
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (rows[i]) begin
            send_vertex(rows[i].v);
            if (rows[i].known) expected_q[$] = rows[i].r;
        end
        drain();

        // sweep viewport extremes and odd sizes, incl. a zero size
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(vcv_pkg::REG_VIEWPORT_WIDTH, 13'd1);
                    write_reg(vcv_pkg::REG_VIEWPORT_HEIGHT, 13'd1);
                end
                1: begin
                    write_reg(vcv_pkg::REG_VIEWPORT_WIDTH, 13'd4096);
                    write_reg(vcv_pkg::REG_VIEWPORT_HEIGHT, 13'd4096);
                end
                2: begin
                    write_reg(vcv_pkg::REG_VIEWPORT_WIDTH, 13'h1fff);
                    write_reg(vcv_pkg::REG_VIEWPORT_HEIGHT, 13'd0);
                end
                3: begin
                    write_reg(vcv_pkg::REG_VIEWPORT_WIDTH, 13'd1921);
                    write_reg(vcv_pkg::REG_VIEWPORT_HEIGHT, 13'd1079);
                end
                4: begin
                    write_reg(vcv_pkg::REG_VIEWPORT_WIDTH, CFGW'($urandom_range(1, 4096)));
                    write_reg(vcv_pkg::REG_VIEWPORT_HEIGHT, CFGW'($urandom_range(1, 4096)));
                end
                default: begin
                    write_reg(vcv_pkg::REG_VIEWPORT_WIDTH, 13'd640);
                    write_reg(vcv_pkg::REG_VIEWPORT_HEIGHT, 13'd480);
                end
            endcase
            rx_steady = (ph == 3);
            if (ph == 1) begin
                hold_len = 300;
                hold_req++;
            end
            for (int n = 0; n < 150; n++) send_vertex(rand_vertex());
            if (ph == 1) begin
                hold_len = 200;
                hold_req++;
                for (int n = 0; n < 60; n++) begin
                    v = rand_vertex();
                    send_vertex(v);
                end
            end
            rx_steady = 0;
            drain();
        end

        $display("%0d vertices sent, %0d results checked over six viewport settings",
                 vertices_in, beats_out);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
